// ----- src/bis_pkg.sv -----
// Package for the blocked index search unit: transfer structs, operation
// codes and configuration register indexes. No dependencies.
`default_nettype none

package bis_pkg;

    localparam int KEY_W   = 16;
    localparam int SLOT_W  = 7;
    localparam int START_W = 7;
    localparam int POS_W   = 8;
    localparam int OP_W    = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;
    localparam int ICNT_W  = 6;
    localparam int DCNT_W  = 8;

    localparam logic [OP_W-1:0] OP_LOAD_INDEX = 2'd0;
    localparam logic [OP_W-1:0] OP_LOAD_DATA  = 2'd1;
    localparam logic [OP_W-1:0] OP_SEARCH     = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_INDEX_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DATA_COUNT  = 2'd1;

    typedef struct packed {
        logic [OP_W-1:0]    operation;
        logic [SLOT_W-1:0]  slot;
        logic signed [KEY_W-1:0] key;
        logic [START_W-1:0] block_start;
    } t_in_item;

    typedef struct packed {
        logic             found;
        logic [POS_W-1:0] position;
    } t_out_item;

endpackage

`default_nettype wire

// ----- src/bis_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
`default_nettype none

module bis_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// ----- src/blocked_index_search_unit.sv -----
// Blocked index search unit: index and data tables in RAM, binary search
// of the index followed by a scan of one data block. Uses bis_pkg, bis_ram.
//
//   channel  | direction | handshake                 | payload
//   ---------+-----------+---------------------------+---------------------
//   command  | in        | i_start & !o_busy         | i_cmd (t_in_item)
//   result   | out       | o_res_valid, one cycle    | o_res (t_out_item)
//   config   | in        | i_cfg_valid & o_cfg_ready | i_cfg_index, i_cfg_data
//
// Loads leave o_busy low. A search runs a binary search of the index, each
// probe one RAM read plus one compare; it ends there when no index key
// reaches the search key. Otherwise it reads the block's own index entry
// and, when the block is not the last one, the next entry for the block
// end, then scans the data keys of the block, each step one RAM read plus
// one compare, until a key matches or the block ends. The result strobe
// comes with the cycle in which o_busy falls. Reset is synchronous, active
// low, and clears only control state and the counts; the tables are
// undefined until loaded. The receiver cannot stall results.
`default_nettype none

module blocked_index_search_unit #(
    parameter int DATA_DEPTH  = 128,
    parameter int INDEX_DEPTH = 32
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_start,
    output logic                              o_busy,
    input  wire bis_pkg::t_in_item            i_cmd,
    output logic                              o_res_valid,
    output bis_pkg::t_out_item                o_res,
    input  wire logic                         i_cfg_valid,
    output logic                              o_cfg_ready,
    input  wire logic [bis_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [bis_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    import bis_pkg::*;

    // Address widths of the two tables, and widths of the search counters:
    // lo/hi/m reach INDEX_DEPTH, j/end/n reach DATA_DEPTH or a block start.
    localparam int IA = (INDEX_DEPTH > 1) ? $clog2(INDEX_DEPTH) : 1;
    localparam int DA = (DATA_DEPTH > 1) ? $clog2(DATA_DEPTH) : 1;
    localparam int IW = IA + 1;
    localparam int JW = (DA + 1 > START_W + 1) ? DA + 1 : START_W + 1;
    localparam int IE_W = START_W + KEY_W;

    typedef struct packed {
        logic [START_W-1:0] start;
        logic [KEY_W-1:0]   key;
    } t_index_entry;

    typedef enum logic [2:0] {
        S_IDLE,
        S_BS_RD,
        S_BS_CMP,
        S_ST_RD,
        S_ST_CMP,
        S_END_CMP,
        S_SCAN_RD,
        S_SCAN_CMP
    } t_state;

    t_state                 r_state;
    logic [ICNT_W-1:0]      r_index_count;
    logic [DCNT_W-1:0]      r_data_count;
    logic signed [KEY_W-1:0] r_key;
    logic [IW-1:0]          r_lo;
    logic [IW-1:0]          r_hi;
    logic [IW-1:0]          r_m;
    logic [IW-1:0]          r_mid;
    logic [JW-1:0]          r_j;
    logic [JW-1:0]          r_end;
    logic [JW-1:0]          r_n;
    logic                   r_res_valid;
    t_out_item              r_res;

    logic                   accept;
    logic [IW-1:0]          sat_m;
    logic [JW-1:0]          sat_n;
    logic [IW-1:0]          mid;
    logic [IW-1:0]          lo_next;
    logic [JW-1:0]          rd_start;
    t_index_entry           idx_wdata;
    t_index_entry           idx_rdata;
    logic [IE_W-1:0]        idx_rdata_raw;
    logic                   idx_we;
    logic                   idx_re;
    logic [IA-1:0]          idx_raddr;
    logic                   dat_we;
    logic                   dat_re;
    logic [KEY_W-1:0]       dat_rdata;

    assign accept      = i_start && (r_state == S_IDLE);
    assign o_busy      = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

    // Saturate the counts at the table depths.
    always_comb begin
        if (int'(r_index_count) >= INDEX_DEPTH) begin
            sat_m = IW'(INDEX_DEPTH);
        end else begin
            sat_m = IW'(r_index_count);
        end
        if (int'(r_data_count) >= DATA_DEPTH) begin
            sat_n = JW'(DATA_DEPTH);
        end else begin
            sat_n = JW'(r_data_count);
        end
    end

    assign mid       = r_lo + ((r_hi - r_lo) >> 1);
    assign lo_next   = r_lo + IW'(1);
    assign idx_rdata = t_index_entry'(idx_rdata_raw);
    assign rd_start  = JW'(idx_rdata.start);

    // Loads write the tables from idle; a slot beyond a table is dropped.
    assign idx_we = accept && (i_cmd.operation == OP_LOAD_INDEX)
                    && (int'(i_cmd.slot) < INDEX_DEPTH);
    assign dat_we = accept && (i_cmd.operation == OP_LOAD_DATA)
                    && (int'(i_cmd.slot) < DATA_DEPTH);
    assign idx_wdata.start = i_cmd.block_start;
    assign idx_wdata.key   = i_cmd.key;

    // Index read address: the probe while searching, then the block's own
    // entry, then the next entry for the block end.
    always_comb begin
        idx_re    = 1'b0;
        idx_raddr = IA'(r_lo);
        case (r_state)
            S_BS_RD: begin
                idx_re    = (r_lo < r_hi);
                idx_raddr = IA'(mid);
            end
            S_ST_RD: begin
                idx_re    = 1'b1;
                idx_raddr = IA'(r_lo);
            end
            S_ST_CMP: begin
                idx_re    = (lo_next < r_m);
                idx_raddr = IA'(lo_next);
            end
            default: begin
                idx_re    = 1'b0;
                idx_raddr = IA'(r_lo);
            end
        endcase
    end

    assign dat_re = (r_state == S_SCAN_RD) && (r_j < r_end);

    bis_ram #(
        .WIDTH (IE_W),
        .DEPTH (INDEX_DEPTH)
    ) u_index_ram (
        .i_clk   (i_clk),
        .i_we    (idx_we),
        .i_waddr (IA'(i_cmd.slot)),
        .i_wdata (idx_wdata),
        .i_re    (idx_re),
        .i_raddr (idx_raddr),
        .o_rdata (idx_rdata_raw)
    );

    bis_ram #(
        .WIDTH (KEY_W),
        .DEPTH (DATA_DEPTH)
    ) u_data_ram (
        .i_clk   (i_clk),
        .i_we    (dat_we),
        .i_waddr (DA'(i_cmd.slot)),
        .i_wdata (i_cmd.key),
        .i_re    (dat_re),
        .i_raddr (r_j[DA-1:0]),
        .o_rdata (dat_rdata)
    );

    // Sequencer, counts and result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_index_count <= '0;
            r_data_count  <= '0;
            r_res_valid   <= 1'b0;
        end else begin
            r_res_valid <= 1'b0;

            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_INDEX_COUNT: r_index_count <= i_cfg_data[ICNT_W-1:0];
                    CFG_DATA_COUNT:  r_data_count  <= i_cfg_data[DCNT_W-1:0];
                    default: ;
                endcase
            end

            case (r_state)
                S_IDLE: begin
                    if (accept && (i_cmd.operation == OP_SEARCH)) begin
                        r_key   <= i_cmd.key;
                        r_lo    <= '0;
                        r_hi    <= sat_m;
                        r_m     <= sat_m;
                        r_n     <= sat_n;
                        r_state <= S_BS_RD;
                    end
                end
                S_BS_RD: begin
                    if (r_lo < r_hi) begin
                        r_mid   <= mid;
                        r_state <= S_BS_CMP;
                    end else if (r_lo >= r_m) begin
                        // No index key at least the search key.
                        r_res       <= '0;
                        r_res_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end else begin
                        r_state <= S_ST_RD;
                    end
                end
                S_BS_CMP: begin
                    if ($signed(idx_rdata.key) >= r_key) begin
                        r_hi <= r_mid;
                    end else begin
                        r_lo <= r_mid + IW'(1);
                    end
                    r_state <= S_BS_RD;
                end
                S_ST_RD: begin
                    r_state <= S_ST_CMP;
                end
                S_ST_CMP: begin
                    r_j <= rd_start;
                    if (lo_next < r_m) begin
                        r_state <= S_END_CMP;
                    end else begin
                        r_end   <= r_n;
                        r_state <= S_SCAN_RD;
                    end
                end
                S_END_CMP: begin
                    // Clamp the block end at the data count.
                    r_end   <= (rd_start > r_n) ? r_n : rd_start;
                    r_state <= S_SCAN_RD;
                end
                S_SCAN_RD: begin
                    if (r_j < r_end) begin
                        r_state <= S_SCAN_CMP;
                    end else begin
                        r_res       <= '0;
                        r_res_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                S_SCAN_CMP: begin
                    if (dat_rdata == r_key) begin
                        r_res.found    <= 1'b1;
                        r_res.position <= POS_W'(r_j + JW'(1));
                        r_res_valid    <= 1'b1;
                        r_state        <= S_IDLE;
                    end else begin
                        r_j     <= r_j + JW'(1);
                        r_state <= S_SCAN_RD;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ----- verif/tb_blocked_index_search_unit.sv -----
// Self-checking testbench for blocked_index_search_unit: table loads, index
// searches and count register writes, checked against a built-in predictor.
// Depends on bis_pkg and the RTL of the unit only.
`default_nettype none

module tb_blocked_index_search_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import bis_pkg::*;

    localparam int DATA_DEPTH  = 128;
    localparam int INDEX_DEPTH = 32;
    // Operation code that the unit has to ignore.
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    // Effective loads plus searches after which the random part stops.
    localparam int ITEM_TARGET = 950;
    // Cycles without any transfer before the run is declared hung. The
    // slowest search scans a full 128-key block.
    localparam int HANG_LIMIT = 2000;
    // Cycles to let a trailing load settle before a register write.
    localparam int LOAD_TAIL = 4;
    localparam int END_TAIL  = 10;
    localparam int MAX_PRINTS = 40;

    // Predictor: mirrors the tables and counts, and holds the results that
    // searches still owe, oldest first.
    class search_checker;
        logic signed [KEY_W-1:0]   idx_key [INDEX_DEPTH];
        logic        [START_W-1:0] idx_start [INDEX_DEPTH];
        logic signed [KEY_W-1:0]   dat_key [DATA_DEPTH];
        logic [ICNT_W-1:0] index_count;
        logic [DCNT_W-1:0] data_count;
        t_out_item   pending_results [$];
        int unsigned errors;
        int unsigned loads;
        int unsigned searches;
        int unsigned hits;

        function new();
            index_count = '0;
            data_count  = '0;
            errors   = 0;
            loads    = 0;
            searches = 0;
            hits     = 0;
        endfunction

        task report_mismatch(string what, int got, int want);
            if (errors < MAX_PRINTS)
                $display("[%0t] MISMATCH %s: got %0d, expected %0d", $realtime, what, got, want);
            errors++;
        endtask

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
            if (idx == CFG_INDEX_COUNT)
                index_count = value[ICNT_W-1:0];
            else if (idx == CFG_DATA_COUNT)
                data_count = value[DCNT_W-1:0];
        endfunction

        // Binary search of the index for the first entry not below the key,
        // then a linear scan of that entry's block.
        function t_out_item locate_key(logic signed [KEY_W-1:0] key);
            t_out_item r;
            int m, n, lo, hi, mid, stop, j;
            r = '0;
            m = (index_count > INDEX_DEPTH) ? INDEX_DEPTH : int'(index_count);
            n = (data_count > DATA_DEPTH) ? DATA_DEPTH : int'(data_count);
            lo = 0;
            hi = m;
            while (lo < hi) begin
                mid = lo + (hi - lo) / 2;
                if (idx_key[mid] >= key)
                    hi = mid;
                else
                    lo = mid + 1;
            end
            if (lo >= m)
                return r;
            stop = (lo + 1 < m) ? int'(idx_start[lo + 1]) : n;
            if (stop > n)
                stop = n;
            for (j = int'(idx_start[lo]); j < stop; j++) begin
                if (dat_key[j] == key) begin
                    r.found    = 1'b1;
                    r.position = POS_W'(j + 1);
                    return r;
                end
            end
            return r;
        endfunction

        task note_command(t_in_item c);
            t_out_item want;
            case (c.operation)
                OP_LOAD_INDEX: begin
                    if (c.slot < INDEX_DEPTH) begin
                        idx_key[c.slot]   = c.key;
                        idx_start[c.slot] = c.block_start;
                        loads++;
                    end
                end
                OP_LOAD_DATA: begin
                    dat_key[c.slot] = c.key;
                    loads++;
                end
                OP_SEARCH: begin
                    want = locate_key(c.key);
                    pending_results.push_back(want);
                    searches++;
                    if (want.found)
                        hits++;
                end
                default: ;
            endcase
        endtask

        task check_result(t_out_item got);
            t_out_item want;
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result, position", got.position, 0);
                return;
            end
            want = pending_results.pop_front();
            if (got.found !== want.found)
                report_mismatch("found", got.found, want.found);
            if (got.position !== want.position)
                report_mismatch("position", got.position, want.position);
        endtask
    endclass

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_start     = 1'b0;
    t_in_item              i_cmd       = '0;
    logic                  i_cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;
    logic                  o_busy;
    logic                  o_res_valid;
    t_out_item             o_res;
    logic                  o_cfg_ready;

    search_checker bench = new();
    int unsigned   gap_max = 5;
    int unsigned   cfg_writes = 0;
    int unsigned   layouts = 0;
    int unsigned   stall_cycles = 0;

    blocked_index_search_unit #(
        .DATA_DEPTH (DATA_DEPTH),
        .INDEX_DEPTH(INDEX_DEPTH)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_start),
        .o_busy     (o_busy),
        .i_cmd      (i_cmd),
        .o_res_valid(o_res_valid),
        .o_res      (o_res),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Results cannot be held off: take every strobed result at the edge that
    // closes its cycle and compare it with the oldest pending expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && o_res_valid === 1'b1)
            bench.check_result(o_res);
    end

    // Watchdog: count edges at which no transfer of any kind happens.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_start && o_busy === 1'b0) || o_res_valid === 1'b1
                || (i_cfg_valid && o_cfg_ready === 1'b1)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= HANG_LIMIT) begin
            $display("Timeout: no transfer for %0d cycles", HANG_LIMIT);
            $display("Some tests failed");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    function automatic t_in_item make_cmd(logic [OP_W-1:0] op, int slot, int key, int start);
        t_in_item c;
        c.operation   = op;
        c.slot        = SLOT_W'(slot);
        c.key         = KEY_W'(key);
        c.block_start = START_W'(start);
        return c;
    endfunction

    // Issue one command. Called right after a rising edge; idle for a random
    // number of cycles, then hold start until the unit takes the transfer.
    // With no gap, start stays high and only the payload advances.
    task automatic send(t_in_item c);
        int unsigned gap;
        gap = $urandom_range(0, gap_max);
        if (gap > 0) begin
            i_start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_start <= 1'b1;
        i_cmd   <= c;
        do @(posedge i_clk); while (o_busy !== 1'b0);
        bench.note_command(c);
    endtask

    // Drop start and hold until every pending search has answered, then let
    // a trailing load finish.
    task automatic settle(int unsigned tail);
        i_start <= 1'b0;
        do @(posedge i_clk); while (bench.pending_results.size() != 0);
        repeat (tail) @(posedge i_clk);
    endtask

    // Keep valid high across back-to-back writes; set_counts drops it.
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        bench.write_reg(idx, value);
        cfg_writes++;
    endtask

    task automatic set_counts(logic [CFG_DATA_W-1:0] icount, logic [CFG_DATA_W-1:0] dcount);
        settle(LOAD_TAIL);
        write_reg(CFG_INDEX_COUNT, icount);
        write_reg(CFG_DATA_COUNT, dcount);
        i_cfg_valid <= 1'b0;
    endtask

    // Occasionally slip in an item that the unit must ignore: the unused
    // operation code, or an index load aimed past the index table.
    task automatic maybe_noise();
        if ($urandom_range(0, 15) == 0) begin
            if ($urandom_range(0, 1) == 0)
                send(make_cmd(OP_UNUSED, $urandom_range(0, 127), $urandom,
                              $urandom_range(0, 127)));
            else
                send(make_cmd(OP_LOAD_INDEX, $urandom_range(INDEX_DEPTH, 127), $urandom,
                              $urandom_range(0, 127)));
        end
    endtask

    // Write every table entry once so that no search ever reads an entry
    // that was never loaded.
    task automatic fill_tables();
        int i;
        for (i = 0; i < INDEX_DEPTH; i++)
            send(make_cmd(OP_LOAD_INDEX, i, $urandom, $urandom_range(0, 127)));
        for (i = 0; i < DATA_DEPTH; i++)
            send(make_cmd(OP_LOAD_DATA, i, $urandom, $urandom_range(0, 127)));
    endtask

    // Hand-picked layout: three blocks over six keys with both key extremes,
    // a duplicate key, then a block starting past the data count, an index
    // with nothing above a key, and an out-of-order index.
    task automatic directed_checks();
        set_counts(8'd3, 8'd6);
        send(make_cmd(OP_LOAD_DATA, 0, -32768, 0));
        send(make_cmd(OP_LOAD_DATA, 1, -5, 0));
        send(make_cmd(OP_LOAD_DATA, 2, 0, 0));
        send(make_cmd(OP_LOAD_DATA, 3, 7, 0));
        send(make_cmd(OP_LOAD_DATA, 4, 7, 0));
        send(make_cmd(OP_LOAD_DATA, 5, 32767, 0));
        send(make_cmd(OP_LOAD_DATA, 127, -1, 127));
        send(make_cmd(OP_LOAD_INDEX, 0, -5, 0));
        send(make_cmd(OP_LOAD_INDEX, 1, 7, 2));
        send(make_cmd(OP_LOAD_INDEX, 2, 32767, 5));
        // load past the index depth, and the unused code: both dropped
        send(make_cmd(OP_LOAD_INDEX, 127, 32767, 127));
        send(make_cmd(OP_UNUSED, 127, -1, 127));
        send(make_cmd(OP_SEARCH, 0, -32768, 0));
        send(make_cmd(OP_SEARCH, 127, 32767, 127));
        send(make_cmd(OP_SEARCH, 0, 7, 0));
        send(make_cmd(OP_SEARCH, 0, 6, 0));
        send(make_cmd(OP_SEARCH, 0, -5, 0));
        // last block starts beyond the data count: nothing to scan
        send(make_cmd(OP_LOAD_INDEX, 2, 100, 7));
        send(make_cmd(OP_SEARCH, 0, 50, 0));
        send(make_cmd(OP_SEARCH, 0, 32767, 0));
        // first index key now out of order
        send(make_cmd(OP_LOAD_INDEX, 0, 1000, 0));
        send(make_cmd(OP_SEARCH, 0, 0, 0));
        send(make_cmd(OP_SEARCH, 0, -32768, 0));
    endtask

    // One random layout: sorted data keys cut into blocks, an index holding
    // each block's largest key, then a burst of searches.
    task automatic run_layout(bit full);
        logic signed [KEY_W-1:0]   dkeys [DATA_DEPTH];
        logic signed [KEY_W-1:0]   ikeys [INDEX_DEPTH];
        logic        [START_W-1:0] starts [INDEX_DEPTH];
        int m, n, b, j, key, step_max, stop, sel, probes;
        logic [CFG_DATA_W-1:0] icount, dcount;

        n = full ? DATA_DEPTH : $urandom_range(0, 24);
        if (full)
            m = INDEX_DEPTH;
        else
            m = $urandom_range(0, (n + 2 > INDEX_DEPTH) ? INDEX_DEPTH : n + 2);
        step_max = full ? 500 : 2000;
        gap_max  = ($urandom_range(0, 3) == 0) ? 0 : 5;

        key = -32768 + $urandom_range(0, full ? 1000 : 2000);
        for (j = 0; j < n; j++) begin
            dkeys[j] = KEY_W'(key);
            if ($urandom_range(0, 7) != 0)
                key += $urandom_range(1, step_max);
        end
        for (b = 0; b < m; b++) begin
            if (b == 0)
                starts[b] = '0;
            else begin
                j = int'(starts[b-1]);
                j += $urandom_range(0, (2 * (n - j)) / (m - b + 1));
                starts[b] = START_W'((j > n) ? n : j);
            end
        end
        for (b = 0; b < m; b++) begin
            stop = (b + 1 < m) ? int'(starts[b+1]) : n;
            if (stop > int'(starts[b]))
                ikeys[b] = dkeys[stop-1];
            else
                ikeys[b] = (b > 0) ? ikeys[b-1] : KEY_W'(-32768);
        end

        // Counts at the table depth are sometimes written as larger values,
        // which the unit has to saturate.
        icount = CFG_DATA_W'(m);
        if (m == INDEX_DEPTH && $urandom_range(0, 1) == 1)
            icount = CFG_DATA_W'($urandom_range(INDEX_DEPTH + 1, 63))
                   | ($urandom_range(0, 1) ? 8'hC0 : 8'h00);
        dcount = CFG_DATA_W'(n);
        if (n == DATA_DEPTH && $urandom_range(0, 1) == 1)
            dcount = CFG_DATA_W'($urandom_range(DATA_DEPTH + 1, 255));
        set_counts(icount, dcount);
        layouts++;

        for (b = 0; b < m; b++) begin
            maybe_noise();
            send(make_cmd(OP_LOAD_INDEX, b, ikeys[b], starts[b]));
        end
        for (j = 0; j < n; j++) begin
            maybe_noise();
            send(make_cmd(OP_LOAD_DATA, j, dkeys[j], $urandom_range(0, 127)));
        end

        probes = $urandom_range(15, 40);
        repeat (probes) begin
            maybe_noise();
            sel = $urandom_range(0, 39);
            if (sel == 0 && n > 0) begin
                // corrupt a data key: breaks the ordering of this layout
                send(make_cmd(OP_LOAD_DATA, $urandom_range(0, n - 1), $urandom, 0));
                continue;
            end
            if (n > 0 && sel < 24)
                key = dkeys[$urandom_range(0, n - 1)];
            else if (n > 0 && sel < 30)
                key = dkeys[$urandom_range(0, n - 1)] + ($urandom_range(0, 1) ? 1 : -1);
            else if (m > 0 && sel < 34)
                key = ikeys[$urandom_range(0, m - 1)];
            else
                key = $urandom;
            send(make_cmd(OP_SEARCH, $urandom_range(0, 127), key, $urandom_range(0, 127)));
        end
    endtask

    initial begin
        bit full;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Counts are zero out of reset: a search reads no table entry.
        send(make_cmd(OP_SEARCH, 0, 32767, 0));
        fill_tables();
        directed_checks();

        // Random layouts; the first one uses both tables in full.
        full = 1'b1;
        while (bench.loads + bench.searches < ITEM_TARGET) begin
            run_layout(full);
            full = ($urandom_range(0, 9) == 0);
        end

        settle(END_TAIL);
        $display("Covered %0d searches (%0d hits) and %0d table loads over %0d layouts,",
                 bench.searches, bench.hits, bench.loads, layouts);
        $display("with %0d count register writes; %0d mismatches.", cfg_writes, bench.errors);
        if (bench.errors == 0 && bench.pending_results.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ----- files.f -----
src/bis_pkg.sv
src/bis_ram.sv
src/blocked_index_search_unit.sv
verif/tb_blocked_index_search_unit.sv
